// File: rtl/priority_order_queue_assert.svh
// Assertion helpers for the order queue.
`ifndef PRIORITY_ORDER_QUEUE_ASSERT_SVH
`define PRIORITY_ORDER_QUEUE_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define POQ_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("order queue assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define POQ_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("order queue assertion failed");

`endif

// File: rtl/poq_pkg.sv
package poq_pkg;

  localparam int OccW = 5;

  localparam logic ActInsert  = 1'b0;
  localparam logic ActExtract = 1'b1;

  typedef enum logic [1:0] {
    StInserted  = 2'd0,
    StFull      = 2'd1,
    StExtracted = 2'd2,
    StEmpty     = 2'd3
  } status_e;

  typedef struct packed {
    logic [31:0] id;
    logic [15:0] prep;
    logic [2:0]  level;
    logic [31:0] stamp;
  } entry_t;

  // Strictly better only: on a full tie the earlier slot stays best.
  function automatic logic better(entry_t cand, entry_t best);
    return (cand.level > best.level) ||
           ((cand.level == best.level) && (cand.stamp < best.stamp));
  endfunction

endpackage

// File: rtl/poq_entry_ram.sv
module poq_entry_ram #(
  parameter int Depth = 16,
  localparam int AddrW = $clog2(Depth)
) (
  input  logic                clk_i,
  input  logic                we_i,
  input  logic [AddrW-1:0]    waddr_i,
  input  poq_pkg::entry_t     wdata_i,
  input  logic                re_i,
  input  logic [AddrW-1:0]    raddr_i,
  output poq_pkg::entry_t     rdata_o
);

  poq_pkg::entry_t mem [Depth];
  poq_pkg::entry_t rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// File: rtl/priority_order_queue.sv
// Priority order queue: a table of up to QUEUE_DEPTH orders held in one
// single-port-read, single-port-write memory.
// Command channel: a beat is taken when start is high and busy is low.
// action_i = 0 inserts the carried order at the tail, action_i = 1 extracts
// the best order (highest priority, then smallest timestamp, then oldest).
// Result channel: exactly one beat per command, shown for one cycle while
// res_valid_o is high; the receiver cannot stall it.
// An insert, a drop on full and an extract on empty give their result the
// cycle after the command. An extract reads every held entry in S_SCAN to
// find the best one, then, unless that one sits in the last slot, moves each
// later entry down one place in S_SHIFT to close the gap; busy is high
// until the result cycle. The scan and the compaction both go through the
// one memory read port, one entry per cycle.
// Throughput: inserts and the immediate answers take a command every cycle;
// after an extract the next command can be taken in its result cycle.
// Reset empties the table at once; no clearing pass is needed.
module priority_order_queue #(
  parameter int QUEUE_DEPTH = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start,
  output logic        busy,
  input  logic        action_i,
  input  logic [31:0] order_id_i,
  input  logic [15:0] prep_time_i,
  input  logic [2:0]  priority_req_i,
  input  logic [31:0] enqueue_time_i,
  output logic        res_valid_o,
  output logic [1:0]  status_o,
  output logic [31:0] out_id_o,
  output logic [15:0] out_prep_time_o,
  output logic [2:0]  out_priority_o,
  output logic [31:0] out_time_o,
  output logic [4:0]  occupancy_o
);

  localparam int AW   = $clog2(QUEUE_DEPTH);
  localparam int CntW = $clog2(QUEUE_DEPTH + 1);

  typedef enum logic [2:0] {
    S_IDLE  = 3'b001,
    S_SCAN  = 3'b010,
    S_SHIFT = 3'b100
  } state_e;

  state_e                    state_q, state_d;
  logic [CntW-1:0]           cnt_q, cnt_d, cnt_m1;
  logic [AW-1:0]             idx_q, idx_d;
  logic [AW-1:0]             bidx_q, bidx_d, cur_bidx;
  poq_pkg::entry_t           best_q, best_d, cur_best;
  logic                      take;
  logic                      res_valid_q, res_valid_d;
  poq_pkg::status_e          status_q, status_d;
  poq_pkg::entry_t           res_q, res_d;
  logic [poq_pkg::OccW-1:0]  occ_q;

  logic                      we, re;
  logic [AW-1:0]             waddr, raddr;
  poq_pkg::entry_t           wdata, rdata;

  poq_entry_ram #(
    .Depth (QUEUE_DEPTH)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .re_i    (re),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  assign cnt_m1   = cnt_q - CntW'(1);
  assign take     = (idx_q == '0) || poq_pkg::better(rdata, best_q);
  assign cur_best = take ? rdata : best_q;
  assign cur_bidx = take ? idx_q : bidx_q;

  always_comb begin
    state_d     = state_q;
    cnt_d       = cnt_q;
    idx_d       = idx_q;
    bidx_d      = bidx_q;
    best_d      = best_q;
    res_valid_d = 1'b0;
    status_d    = status_q;
    res_d       = res_q;
    we          = 1'b0;
    waddr       = idx_q;
    wdata       = rdata;
    re          = 1'b0;
    raddr       = '0;
    unique case (state_q)
      S_IDLE: begin
        if (start) begin
          if (action_i == poq_pkg::ActInsert) begin
            res_valid_d = 1'b1;
            res_d       = '0;
            if (cnt_q == CntW'(QUEUE_DEPTH)) begin
              status_d = poq_pkg::StFull;
            end else begin
              we          = 1'b1;
              waddr       = AW'(cnt_q);
              wdata.id    = order_id_i;
              wdata.prep  = prep_time_i;
              wdata.level = priority_req_i;
              wdata.stamp = enqueue_time_i;
              cnt_d       = cnt_q + CntW'(1);
              status_d    = poq_pkg::StInserted;
            end
          end else if (cnt_q == '0) begin
            res_valid_d = 1'b1;
            res_d       = '0;
            status_d    = poq_pkg::StEmpty;
          end else begin
            re      = 1'b1;
            raddr   = '0;
            idx_d   = '0;
            state_d = S_SCAN;
          end
        end
      end
      S_SCAN: begin
        // rdata holds slot idx_q this cycle
        best_d = cur_best;
        bidx_d = cur_bidx;
        if (CntW'(idx_q) == cnt_m1) begin
          if (CntW'(cur_bidx) == cnt_m1) begin
            res_valid_d = 1'b1;
            status_d    = poq_pkg::StExtracted;
            res_d       = cur_best;
            cnt_d       = cnt_m1;
            state_d     = S_IDLE;
          end else begin
            re      = 1'b1;
            raddr   = AW'(CntW'(cur_bidx) + CntW'(1));
            idx_d   = cur_bidx;
            state_d = S_SHIFT;
          end
        end else begin
          re    = 1'b1;
          raddr = AW'(CntW'(idx_q) + CntW'(1));
          idx_d = AW'(CntW'(idx_q) + CntW'(1));
        end
      end
      S_SHIFT: begin
        // rdata holds slot idx_q+1; move it down one place
        we    = 1'b1;
        waddr = idx_q;
        wdata = rdata;
        if ((CntW'(idx_q) + CntW'(2)) < cnt_q) begin
          re    = 1'b1;
          raddr = AW'(CntW'(idx_q) + CntW'(2));
          idx_d = AW'(CntW'(idx_q) + CntW'(1));
        end else begin
          res_valid_d = 1'b1;
          status_d    = poq_pkg::StExtracted;
          res_d       = best_q;
          cnt_d       = cnt_m1;
          state_d     = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      cnt_q       <= '0;
      res_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      res_valid_q <= res_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    idx_q  <= idx_d;
    bidx_q <= bidx_d;
    best_q <= best_d;
    if (res_valid_d) begin
      status_q <= status_d;
      res_q    <= res_d;
      occ_q    <= poq_pkg::OccW'(cnt_d);
    end
  end

  assign busy            = (state_q != S_IDLE);
  assign res_valid_o     = res_valid_q;
  assign status_o        = status_q;
  assign out_id_o        = res_q.id;
  assign out_prep_time_o = res_q.prep;
  assign out_priority_o  = res_q.level;
  assign out_time_o      = res_q.stamp;
  assign occupancy_o     = occ_q;

`include "priority_order_queue_assert.svh"

  `POQ_ASSERT_IMP(a_strobe_idle, clk_i, rst_ni, res_valid_q, state_q == S_IDLE)
  `POQ_ASSERT_NXT(a_cmd_answered, clk_i, rst_ni, start && !busy, res_valid_q || busy)
  `POQ_ASSERT_IMP(a_cnt_bound, clk_i, rst_ni, 1'b1, cnt_q <= CntW'(QUEUE_DEPTH))
  `POQ_ASSERT_IMP(a_empty_zero, clk_i, rst_ni, res_valid_q && (status_q == poq_pkg::StEmpty), cnt_q == '0)

endmodule

// File: tb/sv/priority_order_queue_tb.sv
module priority_order_queue_tb;

  localparam int Depth     = 16;
  localparam int ClkPeriod = 20;
  localparam int MaxCycles = 1_000_000;
  localparam int RandItems = 1550;
  localparam int DrainWait = 4 * Depth;

  typedef struct packed {
    logic        act;
    logic [31:0] id;
    logic [15:0] prep;
    logic [2:0]  level;
    logic [31:0] stamp;
  } cmd_t;

  typedef struct packed {
    poq_pkg::status_e status;
    logic [31:0]      id;
    logic [15:0]      prep;
    logic [2:0]       level;
    logic [31:0]      stamp;
    logic [4:0]       occ;
  } res_t;

  typedef struct packed {
    cmd_t c;
    logic typed;
    res_t r;
  } dir_row_t;

  logic        clk_i;
  logic        rst_ni;
  logic        start;
  logic        busy;
  logic        action_i;
  logic [31:0] order_id_i;
  logic [15:0] prep_time_i;
  logic [2:0]  priority_req_i;
  logic [31:0] enqueue_time_i;
  logic        res_valid_o;
  logic [1:0]  status_o;
  logic [31:0] out_id_o;
  logic [15:0] out_prep_time_o;
  logic [2:0]  out_priority_o;
  logic [31:0] out_time_o;
  logic [4:0]  occupancy_o;

  // typed expectation that rides along with the beat being driven
  logic        cur_typed;
  res_t        cur_typed_res;

  poq_pkg::entry_t held[Depth];
  int          held_cnt;
  res_t        pending_res[$];
  dir_row_t    dir_tab[$];
  int          err_cnt;
  int          idle_pct;
  res_t        got;
  res_t        want;

  priority_order_queue #(
    .QUEUE_DEPTH(Depth)
  ) i_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start          (start),
    .busy           (busy),
    .action_i       (action_i),
    .order_id_i     (order_id_i),
    .prep_time_i    (prep_time_i),
    .priority_req_i (priority_req_i),
    .enqueue_time_i (enqueue_time_i),
    .res_valid_o    (res_valid_o),
    .status_o       (status_o),
    .out_id_o       (out_id_o),
    .out_prep_time_o(out_prep_time_o),
    .out_priority_o (out_priority_o),
    .out_time_o     (out_time_o),
    .occupancy_o    (occupancy_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #(ClkPeriod / 2) clk_i = ~clk_i;
  end

  initial begin
    #(ClkPeriod * MaxCycles);
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  // Own model of the order table: insert at tail, extract best and close up.
  function automatic res_t serve_order(cmd_t c);
    res_t r;
    int   best;
    int   k;
    r = '0;
    if (c.act == poq_pkg::ActInsert) begin
      if (held_cnt >= Depth) begin
        r.status = poq_pkg::StFull;
      end else begin
        held[held_cnt] = '{c.id, c.prep, c.level, c.stamp};
        held_cnt++;
        r.status = poq_pkg::StInserted;
      end
    end else if (held_cnt == 0) begin
      r.status = poq_pkg::StEmpty;
    end else begin
      best = 0;
      for (k = 1; k < held_cnt; k++) begin
        if ((held[k].level > held[best].level) ||
            ((held[k].level == held[best].level) && (held[k].stamp < held[best].stamp)))
          best = k;
      end
      r.id    = held[best].id;
      r.prep  = held[best].prep;
      r.level = held[best].level;
      r.stamp = held[best].stamp;
      for (k = best; k + 1 < held_cnt; k++) held[k] = held[k + 1];
      held_cnt--;
      r.status = poq_pkg::StExtracted;
    end
    r.occ = poq_pkg::OccW'(held_cnt);
    return r;
  endfunction

  // Check result beats first, then record the command beat of this edge.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (res_valid_o) begin
        got = '{poq_pkg::status_e'(status_o), out_id_o, out_prep_time_o, out_priority_o,
                out_time_o, occupancy_o};
        if (pending_res.size() == 0) begin
          err_cnt++;
          if (err_cnt <= 10)
            $display("unexpected result beat: st=%0d id=%h occ=%0d",
                     status_o, out_id_o, occupancy_o);
        end else begin
          want = pending_res.pop_front();
          if (got.status !== want.status || got.id !== want.id ||
              got.prep !== want.prep || got.level !== want.level ||
              got.stamp !== want.stamp || got.occ !== want.occ) begin
            err_cnt++;
            if (err_cnt <= 10)
              $display({"mismatch: exp st=%0d id=%h prep=%h pri=%0d t=%h occ=%0d",
                        " | got st=%0d id=%h prep=%h pri=%0d t=%h occ=%0d"},
                       want.status, want.id, want.prep, want.level, want.stamp, want.occ,
                       got.status, got.id, got.prep, got.level, got.stamp, got.occ);
          end
        end
      end
      if (start && !busy) begin
        want = serve_order('{action_i, order_id_i, prep_time_i, priority_req_i,
                             enqueue_time_i});
        if (cur_typed) want = cur_typed_res;
        pending_res.insert(pending_res.size(), want);
      end
    end
  end

  // Entered at a falling edge, returns at the falling edge after the beat.
  task automatic issue_cmd(cmd_t c, logic typed, res_t r);
    while ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      @(negedge clk_i);
    end
    action_i       <= c.act;
    order_id_i     <= c.id;
    prep_time_i    <= c.prep;
    priority_req_i <= c.level;
    enqueue_time_i <= c.stamp;
    cur_typed      <= typed;
    cur_typed_res  <= r;
    start          <= 1'b1;
    @(posedge clk_i);
    while (busy) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  task automatic add_row(logic act, logic [31:0] id, logic [15:0] prep, logic [2:0] lvl,
                         logic [31:0] stamp, logic typed, res_t r);
    dir_row_t row;
    row = '{'{act, id, prep, lvl, stamp}, typed, r};
    dir_tab.insert(dir_tab.size(), row);
  endtask

  task automatic fill_dir_tab();
    res_t nr;
    nr = '0;
    // extract on empty table, with junk operands
    add_row(poq_pkg::ActExtract, 32'hDEAD_BEEF, 16'h1234, 3'd5, 32'h0000_0042, 1'b1,
            '{poq_pkg::StEmpty, 32'h0, 16'h0, 3'd0, 32'h0, 5'd0});
    add_row(poq_pkg::ActInsert, 32'hFFFF_FFFF, 16'hFFFF, 3'd7, 32'hFFFF_FFFF, 1'b1,
            '{poq_pkg::StInserted, 32'h0, 16'h0, 3'd0, 32'h0, 5'd1});
    add_row(poq_pkg::ActExtract, 32'h0, 16'h0, 3'd0, 32'h0, 1'b1,
            '{poq_pkg::StExtracted, 32'hFFFF_FFFF, 16'hFFFF, 3'd7, 32'hFFFF_FFFF, 5'd0});
    add_row(poq_pkg::ActInsert, 32'h0, 16'h0, 3'd0, 32'h0, 1'b1,
            '{poq_pkg::StInserted, 32'h0, 16'h0, 3'd0, 32'h0, 5'd1});
    add_row(poq_pkg::ActExtract, 32'hFFFF_FFFF, 16'hFFFF, 3'd7, 32'hFFFF_FFFF, 1'b1,
            '{poq_pkg::StExtracted, 32'h0, 16'h0, 3'd0, 32'h0, 5'd0});
    // fill the table with ties on stamp and level
    add_row(poq_pkg::ActInsert, 32'h10, 16'd10, 3'd3, 32'd100, 1'b0, nr);
    add_row(poq_pkg::ActInsert, 32'h11, 16'd11, 3'd3, 32'd50, 1'b0, nr);
    add_row(poq_pkg::ActInsert, 32'h12, 16'd12, 3'd3, 32'd50, 1'b0, nr);
    add_row(poq_pkg::ActInsert, 32'h13, 16'd13, 3'd7, 32'd300, 1'b0, nr);
    add_row(poq_pkg::ActInsert, 32'h14, 16'd14, 3'd7, 32'd300, 1'b0, nr);
    add_row(poq_pkg::ActInsert, 32'h15, 16'd15, 3'd0, 32'd0, 1'b0, nr);
    add_row(poq_pkg::ActInsert, 32'h16, 16'd16, 3'd1, 32'hFFFF_FFFF, 1'b0, nr);
    add_row(poq_pkg::ActInsert, 32'h17, 16'd17, 3'd1, 32'd0, 1'b0, nr);
    add_row(poq_pkg::ActInsert, 32'h18, 16'd18, 3'd2, 32'd7, 1'b0, nr);
    add_row(poq_pkg::ActInsert, 32'h19, 16'd19, 3'd2, 32'd6, 1'b0, nr);
    add_row(poq_pkg::ActInsert, 32'h1A, 16'd20, 3'd2, 32'd5, 1'b0, nr);
    add_row(poq_pkg::ActInsert, 32'h1B, 16'd21, 3'd2, 32'd4, 1'b0, nr);
    add_row(poq_pkg::ActInsert, 32'h1C, 16'd22, 3'd2, 32'd3, 1'b0, nr);
    add_row(poq_pkg::ActInsert, 32'h1D, 16'd23, 3'd2, 32'd2, 1'b0, nr);
    add_row(poq_pkg::ActInsert, 32'h1E, 16'd24, 3'd2, 32'd1, 1'b0, nr);
    add_row(poq_pkg::ActInsert, 32'h1F, 16'd25, 3'd2, 32'd1, 1'b0, nr);
    // table full: dropped
    add_row(poq_pkg::ActInsert, 32'hAAAA_5555, 16'hA5A5, 3'd7, 32'd0, 1'b1,
            '{poq_pkg::StFull, 32'h0, 16'h0, 3'd0, 32'h0, 5'd16});
    add_row(poq_pkg::ActExtract, 32'h0, 16'h0, 3'd0, 32'h0, 1'b0, nr);
    add_row(poq_pkg::ActExtract, 32'h5555_AAAA, 16'h5A5A, 3'd2, 32'h1, 1'b0, nr);
    add_row(poq_pkg::ActExtract, 32'h0, 16'h0, 3'd0, 32'h0, 1'b0, nr);
  endtask

  initial begin
    cmd_t        c;
    res_t        nr;
    logic [31:0] last_stamp;
    int          ins_pct;
    int          n;
    int          ph;
    int          phase_pct[4];

    phase_pct = '{0, 80, 0, 22};
    nr             = '0;
    last_stamp     = '0;
    err_cnt        = 0;
    held_cnt       = 0;
    idle_pct       = 0;
    rst_ni         = 1'b0;
    start          = 1'b0;
    action_i       = poq_pkg::ActInsert;
    order_id_i     = '0;
    prep_time_i    = '0;
    priority_req_i = '0;
    enqueue_time_i = '0;
    cur_typed      = 1'b0;
    cur_typed_res  = '0;

    fill_dir_tab();
    repeat (8) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    foreach (dir_tab[i]) issue_cmd(dir_tab[i].c, dir_tab[i].typed, dir_tab[i].r);

    n = 0;
    for (ph = 0; ph < 4; ph++) begin
      idle_pct = phase_pct[ph];
      repeat (RandItems / 4) begin
        // alternate fill-heavy and drain-heavy stretches to hit full and empty
        ins_pct  = ((n / 40) % 2 == 0) ? 70 : 30;
        c.act    = ($urandom_range(99) < ins_pct) ? poq_pkg::ActInsert : poq_pkg::ActExtract;
        c.id     = $urandom;
        c.prep   = 16'($urandom);
        c.level  = ($urandom_range(2) == 0) ? 3'($urandom_range(1)) : 3'($urandom_range(7));
        case ($urandom_range(3))
          0:       c.stamp = $urandom_range(7);
          1:       c.stamp = $urandom;
          2:       c.stamp = 32'hFFFF_FFF8 + $urandom_range(7);
          default: c.stamp = last_stamp;
        endcase
        if (c.act == poq_pkg::ActInsert) last_stamp = c.stamp;
        issue_cmd(c, 1'b0, nr);
        n++;
      end
    end

    start <= 1'b0;
    while (pending_res.size() != 0) @(negedge clk_i);
    repeat (DrainWait) @(negedge clk_i);

    if (err_cnt == 0 && pending_res.size() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

// File: filelist.f
+incdir+rtl
rtl/poq_pkg.sv
rtl/poq_entry_ram.sv
rtl/priority_order_queue.sv
tb/sv/priority_order_queue_tb.sv
